@@ sv/tmfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfq_pkg
// Shared types and constants for the timestamp match frame queue.
// ----------------------------------------------------------------------------
package tmfq_pkg;

    // Entry storage depth and derived widths
    localparam int DEPTH   = 128;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths
    localparam int TIME_W  = 64;
    localparam int TAG_W   = 32;
    localparam int CAP_W   = 8;
    localparam int FILL_W  = 8;
    localparam int STAT_W  = 3;
    localparam int CMD_W   = 2;
    localparam int ENTRY_W = TIME_W + TAG_W;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = TIME_W + TAG_W + TIME_W + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TAG_W + TIME_W + FILL_W + FILL_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(90);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_MATCH = 2'd2,
        CMD_CLOSE = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_EARLY  = 3'd2,
        ST_RETRY  = 3'd3,
        ST_CLOSED = 3'd4
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    in_load;    // capture the input transaction
        logic    do_push;    // store the captured entry
        logic    do_close;   // close the queue
        logic    drop;       // discard the oldest entry
        logic    rd_newest;  // read the newest entry instead of the next head
        logic    cand_load;  // take the read entry as the result
        logic    set_status; // record a status code
        status_t status;
        logic    out_load;   // load the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        cmd_t cmd;
        logic count_zero;
        logic count_one;
        logic closed;
        logic target_before_rd; // target lies before the entry just read
        logic out_free;
    } dp_stat_t;

endpackage

@@ sv/timestamp_match_frame_queue.sv @@
`timescale 1ns / 1ps
// Timestamp match frame queue: a bounded FIFO of (time, tag) frame entries
// with push, pop, match-to-target-time and close commands, one result per
// transaction. An item is taken when the controller is idle, and its result is
// loaded into the output register once worked: push and close act directly,
// pop reads the oldest entry, a match reads the oldest and then, unless it
// fails early, the newest entry, and a match that returns an entry discards
// entries one at a time. A result waits while the previous one still sits in
// the output register. The pace is set by the single registered read port of
// the entry memory, which the match walks one entry per cycle. The next item is
// accepted as soon as the result sits in the output register, even while it
// waits to be taken. The entry store has no reset; only written entries are ever read.
// ----------------------------------------------------------------------------
// timestamp_match_frame_queue
// Top level: stream ports, capacity register port, controller and datapath.
// ----------------------------------------------------------------------------
module timestamp_match_frame_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    // capacity register
    input  logic                                cfg_wr_en,
    input  logic [tmfq_pkg::CAP_W-1:0]          cfg_wr_data,
    // input transactions
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_time[63:0], frame_tag[95:64], target_time[159:96],
    // clear_on_close[160], zero pad
    input  logic [tmfq_pkg::IN_DATA_W-1:0]      s_tdata,
    // command[1:0]
    input  logic [tmfq_pkg::CMD_W-1:0]          s_tuser,
    // result transactions
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_tag[31:0], out_time[95:32], fill[103:96], high_water[111:104],
    // drained[112], zero pad
    output logic [tmfq_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status[2:0]
    output logic [tmfq_pkg::STAT_W-1:0]         m_tuser
);

    tmfq_pkg::ctrl_cmd_t ctrl_cmd;
    tmfq_pkg::dp_stat_t  dp_stat;

    // Sequence each transaction
    tmfq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // Store entries and build results
    tmfq_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (ctrl_cmd),
        .stat        (dp_stat)
    );

`ifndef NO_ASSERTIONS
    // Drop never issued on an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.drop |-> !dp_stat.count_zero)
        else $error("drop issued on empty queue");

    // One transaction in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // Reported fill never above high-water mark
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[103:96] <= m_tdata[111:104]))
        else $error("fill above high-water mark");

    // Drained only with an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[112]) |-> (m_tdata[103:96] == 8'd0))
        else $error("drained with entries left");
`endif

endmodule

@@ sv/tmfq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfq_datapath
// Entry memory, queue pointers, capacity register, result staging and the
// output register of the timestamp match frame queue.
// ----------------------------------------------------------------------------
module tmfq_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tmfq_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic [tmfq_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [tmfq_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tmfq_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [tmfq_pkg::STAT_W-1:0]         m_tuser,
    input  tmfq_pkg::ctrl_cmd_t                 cmd,
    output tmfq_pkg::dp_stat_t                  stat
);

    localparam int ADDR_W  = tmfq_pkg::ADDR_W;
    localparam int CNT_W   = tmfq_pkg::CNT_W;
    localparam int TIME_W  = tmfq_pkg::TIME_W;
    localparam int TAG_W   = tmfq_pkg::TAG_W;
    localparam int ENTRY_W = tmfq_pkg::ENTRY_W;

    // Control state
    logic [ADDR_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           peak_reg, peak_next;
    logic                       closed_reg, closed_next;
    logic [tmfq_pkg::CAP_W-1:0] capacity_reg;
    logic                       m_tvalid_reg, m_tvalid_next;

    // Captured transaction
    tmfq_pkg::cmd_t             cmd_reg;
    logic signed [TIME_W-1:0]   frame_time_reg;
    logic [TAG_W-1:0]           frame_tag_reg;
    logic signed [TIME_W-1:0]   target_reg;
    logic                       clear_reg;

    // Result staging and output register
    tmfq_pkg::status_t          status_reg;
    logic signed [TIME_W-1:0]   cand_time_reg;
    logic [TAG_W-1:0]           cand_tag_reg;
    logic [tmfq_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [tmfq_pkg::STAT_W-1:0]     m_tuser_reg;

    // Entry memory
    logic [ENTRY_W-1:0]         mem [tmfq_pkg::DEPTH];
    logic [ENTRY_W-1:0]         rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic signed [TIME_W-1:0]   rd_time;

    // Push arithmetic
    logic                       full;
    logic [ADDR_W-1:0]          push_head1;
    logic [CNT_W-1:0]           push_count1;
    logic [CNT_W-1:0]           push_count2;
    logic [CNT_W-1:0]           cap_eff;

    assign rd_time = rd_data_reg[ENTRY_W-1:TAG_W];

    // Clamp capacity into 1..DEPTH
    always_comb
    begin
        if (capacity_reg == '0)
            cap_eff = CNT_W'(1);
        else if (32'(capacity_reg) > 32'(tmfq_pkg::DEPTH))
            cap_eff = CNT_W'(tmfq_pkg::DEPTH);
        else
            cap_eff = CNT_W'(capacity_reg);
    end

    // Make room when storage is full, then find the write slot
    always_comb
    begin
        full        = (count_reg == CNT_W'(tmfq_pkg::DEPTH));
        push_head1  = full ? head_reg + ADDR_W'(1) : head_reg;
        push_count1 = full ? count_reg - CNT_W'(1) : count_reg;
        wr_addr     = push_head1 + push_count1[ADDR_W-1:0];
        push_count2 = push_count1 + CNT_W'(1);
    end

    // Next queue pointers, peak and closed flag
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        if (cmd.do_push)
        begin
            if (push_count2 > cap_eff)
            begin
                head_next  = push_head1 + ADDR_W'(1);
                count_next = push_count2 - CNT_W'(1);
            end
            else
            begin
                head_next  = push_head1;
                count_next = push_count2;
            end
        end
        else if (cmd.drop)
        begin
            head_next  = head_reg + ADDR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.do_close)
        begin
            closed_next = 1'b1;
            if (clear_reg)
            begin
                head_next  = '0;
                count_next = '0;
            end
        end
        peak_next = (count_next > peak_reg) ? count_next : peak_reg;
    end

    // Read the newest entry or the head as it stands after this cycle
    assign rd_addr = cmd.rd_newest ? head_reg + count_reg[ADDR_W-1:0] - ADDR_W'(1)
                                   : head_next;

    // Output register handshake
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            peak_reg     <= '0;
            closed_reg   <= 1'b0;
            capacity_reg <= tmfq_pkg::CAPACITY_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            peak_reg     <= peak_next;
            closed_reg   <= closed_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
            mem[wr_addr] <= {frame_time_reg, frame_tag_reg};
        rd_data_reg <= mem[rd_addr];
    end

    // Capture the transaction and stage the result
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            cmd_reg        <= tmfq_pkg::cmd_t'(s_tuser);
            frame_time_reg <= s_tdata[TIME_W-1:0];
            frame_tag_reg  <= s_tdata[TIME_W+TAG_W-1:TIME_W];
            target_reg     <= s_tdata[2*TIME_W+TAG_W-1:TIME_W+TAG_W];
            clear_reg      <= s_tdata[2*TIME_W+TAG_W];
            status_reg     <= tmfq_pkg::ST_OK;
            cand_time_reg  <= '0;
            cand_tag_reg   <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                // a failed command returns no entry
                status_reg    <= cmd.status;
                cand_time_reg <= '0;
                cand_tag_reg  <= '0;
            end
            else if (cmd.cand_load)
            begin
                cand_time_reg <= rd_time;
                cand_tag_reg  <= rd_data_reg[TAG_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= tmfq_pkg::OUT_DATA_W'({
                (closed_reg && count_reg == '0),
                tmfq_pkg::FILL_W'(peak_reg),
                tmfq_pkg::FILL_W'(count_reg),
                cand_time_reg,
                cand_tag_reg});
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.cmd              = cmd_reg;
        stat.count_zero       = (count_reg == '0);
        stat.count_one        = (count_reg == CNT_W'(1));
        stat.closed           = closed_reg;
        stat.target_before_rd = (target_reg < rd_time);
        stat.out_free         = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ sv/tmfq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfq_ctrl
// Controller state machine: sequences push, pop, match and close through
// the datapath and hands each result to the output register.
// ----------------------------------------------------------------------------
module tmfq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tmfq_pkg::dp_stat_t   stat,
    output tmfq_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_M_OLD,
        S_M_NEW,
        S_M_SCAN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Decode state into datapath commands
    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.status     = tmfq_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.cmd)
                    tmfq_pkg::CMD_PUSH:
                    begin
                        cmd.do_push = 1'b1;
                        state_next  = S_DONE;
                    end
                    tmfq_pkg::CMD_CLOSE:
                    begin
                        cmd.do_close = 1'b1;
                        state_next   = S_DONE;
                    end
                    tmfq_pkg::CMD_POP:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = stat.closed ? tmfq_pkg::ST_CLOSED
                                                         : tmfq_pkg::ST_RETRY;
                            state_next     = S_DONE;
                        end
                        else
                            state_next = S_POP_RD;
                    end
                    tmfq_pkg::CMD_MATCH:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = tmfq_pkg::ST_EMPTY;
                            state_next     = S_DONE;
                        end
                        else
                            state_next = S_M_OLD;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_POP_RD:
            begin
                // take the oldest entry and drop it
                cmd.cand_load = 1'b1;
                cmd.drop      = 1'b1;
                state_next    = S_DONE;
            end
            S_M_OLD:
            begin
                // oldest entry is on the read port
                if (stat.target_before_rd)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = tmfq_pkg::ST_EARLY;
                    state_next     = S_DONE;
                end
                else if (stat.closed)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = tmfq_pkg::ST_CLOSED;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.cand_load = 1'b1;
                    cmd.rd_newest = 1'b1;
                    state_next    = S_M_NEW;
                end
            end
            S_M_NEW:
            begin
                // newest entry is on the read port
                if (!stat.target_before_rd)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = tmfq_pkg::ST_RETRY;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.drop   = 1'b1;
                    state_next = stat.count_one ? S_DONE : S_M_SCAN;
                end
            end
            S_M_SCAN:
            begin
                // advance while the new head is still at or before the target
                if (stat.target_before_rd)
                    state_next = S_DONE;
                else
                begin
                    cmd.cand_load = 1'b1;
                    cmd.drop      = 1'b1;
                    if (stat.count_one)
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ verif/tmfq_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmfq_result_checker
// Watches the capacity port and both stream channels of the frame queue,
// keeps a queue model of its own to work out the result of each input
// transaction, and compares every result transaction with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tmfq_result_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tmfq_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tmfq_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [tmfq_pkg::CMD_W-1:0]      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tmfq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [tmfq_pkg::STAT_W-1:0]     m_tuser,
    output int                              mismatch_count,
    output logic                            results_quiet
);

    import tmfq_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   stamp;
        logic [FILL_W-1:0]   fill;
        logic [FILL_W-1:0]   high_water;
        logic                drained;
    } queue_result_t;

    // Queue model state
    logic [TIME_W-1:0] entry_time [DEPTH];
    logic [TAG_W-1:0]  entry_tag  [DEPTH];
    int                head;
    int                held;
    int                peak;
    logic              closed;
    logic [CAP_W-1:0]  capacity_reg;

    queue_result_t     pending_results [$];
    int                results_seen;

    function automatic void drop_oldest();
        if (held > 0)
        begin
            head = (head + 1) % DEPTH;
            held--;
        end
    endfunction

    // Work out the result of one command and advance the model
    function automatic queue_result_t run_command(input cmd_t cmd,
                                                  input logic [TIME_W-1:0] ftime,
                                                  input logic [TAG_W-1:0] ftag,
                                                  input logic [TIME_W-1:0] target,
                                                  input logic clear);
        queue_result_t res;
        int            wr_slot;
        int            cap_use;
        int            guard;
        logic          walking;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_PUSH:
            begin
                cap_use = (capacity_reg == 0) ? 1 :
                          ((int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg));
                // full storage: the new entry replaces the oldest
                if (held >= DEPTH)
                    drop_oldest();
                wr_slot = (head + held) % DEPTH;
                entry_time[wr_slot] = ftime;
                entry_tag[wr_slot] = ftag;
                held++;
                if (held > cap_use)
                    drop_oldest();
                if (peak < held)
                    peak = held;
            end
            CMD_POP:
            begin
                if (held == 0)
                    res.status = closed ? ST_CLOSED : ST_RETRY;
                else
                begin
                    res.stamp = entry_time[head];
                    res.tag = entry_tag[head];
                    drop_oldest();
                end
            end
            CMD_MATCH:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else if ($signed(target) < $signed(entry_time[head]))
                    res.status = ST_EARLY;
                else if (closed)
                    res.status = ST_CLOSED;
                else if (!($signed(target) <
                           $signed(entry_time[(head + held - 1) % DEPTH])))
                    res.status = ST_RETRY;
                else
                begin
                    // walk to the last entry at or before the target
                    guard = held;
                    walking = 1'b1;
                    while (walking)
                    begin
                        res.stamp = entry_time[head];
                        res.tag = entry_tag[head];
                        drop_oldest();
                        guard--;
                        walking = (guard > 0) && (held > 0) &&
                                  !($signed(target) < $signed(entry_time[head]));
                    end
                end
            end
            default:
            begin
                closed = 1'b1;
                if (clear)
                begin
                    held = 0;
                    head = 0;
                end
            end
        endcase
        res.fill = FILL_W'(held);
        res.high_water = FILL_W'(peak);
        res.drained = closed && (held == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [TIME_W-1:0] seen,
                                   input logic [TIME_W-1:0] wanted);
        $display("result %0d: %s mismatch, got %h, expected %h",
                 results_seen, field, seen, wanted);
        mismatch_count++;
    endtask

    // Compare one result transaction with the oldest prediction
    task automatic check_result();
        queue_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result", TIME_W'(m_tuser), '0);
        end
        else
        begin
            want = pending_results[0];
            pending_results.delete(0);
            if (m_tuser !== want.status)
                report_mismatch("status", TIME_W'(m_tuser), TIME_W'(want.status));
            if (m_tdata[TAG_W-1:0] !== want.tag)
                report_mismatch("out_tag", TIME_W'(m_tdata[TAG_W-1:0]), TIME_W'(want.tag));
            if (m_tdata[TAG_W +: TIME_W] !== want.stamp)
                report_mismatch("out_time", m_tdata[TAG_W +: TIME_W], want.stamp);
            if (m_tdata[TAG_W+TIME_W +: FILL_W] !== want.fill)
                report_mismatch("fill", TIME_W'(m_tdata[TAG_W+TIME_W +: FILL_W]),
                                TIME_W'(want.fill));
            if (m_tdata[TAG_W+TIME_W+FILL_W +: FILL_W] !== want.high_water)
                report_mismatch("high_water",
                                TIME_W'(m_tdata[TAG_W+TIME_W+FILL_W +: FILL_W]),
                                TIME_W'(want.high_water));
            if (m_tdata[TAG_W+TIME_W+2*FILL_W] !== want.drained)
                report_mismatch("drained", TIME_W'(m_tdata[TAG_W+TIME_W+2*FILL_W]),
                                TIME_W'(want.drained));
        end
        results_seen++;
    endtask

    // Track configuration, results and inputs at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head = 0;
            held = 0;
            peak = 0;
            closed = 1'b0;
            capacity_reg = CAPACITY_RESET;
            mismatch_count = 0;
            results_seen = 0;
            pending_results.delete();
            results_quiet <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
                capacity_reg = cfg_wr_data;
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(), run_command(
                    cmd_t'(s_tuser),
                    s_tdata[TIME_W-1:0],
                    s_tdata[TIME_W +: TAG_W],
                    s_tdata[TIME_W+TAG_W +: TIME_W],
                    s_tdata[2*TIME_W+TAG_W]));
            results_quiet <= (pending_results.size() == 0);
        end
    end

endmodule

@@ verif/tb_timestamp_match_frame_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_match_frame_queue
// Drives the frame queue with a directed set of pushes, pops and matches and
// then with phases of mostly rising-time random traffic under several
// capacity settings, ending with a closed-queue phase. A checker beside the
// block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_timestamp_match_frame_queue;

    import tmfq_pkg::*;

    localparam int                CYCLE_LIMIT = 400000;
    localparam logic [TIME_W-1:0] TIME_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0] TIME_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]      cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    int                    mismatch_count;
    logic                  results_quiet;

    // Sender and receiver shaping
    int                    burst_left = 0;
    logic                  steady_sender = 1'b0;
    int                    rx_mode = 1;
    int                    hold_request = 0;
    int                    match_reach = 300;
    logic [TIME_W-1:0]     newest_time = '0;
    int                    cycle_count = 0;

    timestamp_match_frame_queue DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    tmfq_result_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatch_count(mismatch_count),
        .results_quiet (results_quiet)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: own stall pattern, with an optional long hold-off
    initial
    begin : receiver
        int hold_left;
        int beat;
        hold_left = 0;
        beat = 0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((beat % 11) < 7);
                endcase
            end
        end
    end

    // Offer one transaction and hold it until accepted
    task automatic send_item(input cmd_t cmd, input logic [TIME_W-1:0] ftime,
                             input logic [TAG_W-1:0] ftag,
                             input logic [TIME_W-1:0] target, input logic clear);
        if (!steady_sender && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= IN_DATA_W'({clear, target, ftag, ftime});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (!results_quiet)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One random transaction; pushes mostly advance the time base
    task automatic random_item(input int push_w, input int pop_w, input int match_w,
                               input int close_w);
        int                pick;
        int                kind;
        logic [TIME_W-1:0] ftime;
        logic [TIME_W-1:0] target;
        pick = $urandom_range(0, push_w + pop_w + match_w + close_w - 1);
        ftime = {$urandom, $urandom};
        target = {$urandom, $urandom};
        if (pick < push_w)
        begin
            if ($urandom_range(0, 15) != 0)
            begin
                if ($urandom_range(0, 7) != 0)
                    newest_time = newest_time + TIME_W'($urandom_range(1, 40));
                ftime = newest_time;
            end
            send_item(CMD_PUSH, ftime, $urandom, target, 1'($urandom));
        end
        else if (pick < push_w + pop_w)
        begin
            send_item(CMD_POP, ftime, $urandom, target, 1'($urandom));
        end
        else if (pick < push_w + pop_w + match_w)
        begin
            kind = $urandom_range(0, 15);
            case (kind)
                0: target = target;
                1: target = newest_time;
                2: target = newest_time + TIME_W'($urandom_range(1, 1000));
                3: target = newest_time - TIME_W'(100000);
                default: target = newest_time - TIME_W'($urandom_range(1, match_reach));
            endcase
            send_item(CMD_MATCH, ftime, $urandom, target, 1'($urandom));
        end
        else
        begin
            send_item(CMD_CLOSE, ftime, $urandom, target, 1'($urandom_range(0, 3) == 0));
        end
    endtask

    // Watchdog
    initial
    begin
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_timestamp_match_frame_queue: errors");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, time extremes, walks and duplicates
        send_item(CMD_POP, TIME_MAX, 32'hFFFF_FFFF, TIME_MIN, 1'b1);
        send_item(CMD_MATCH, '0, '0, '0, 1'b0);
        send_item(CMD_PUSH, TIME_MIN, 32'hFFFF_FFFF, TIME_MAX, 1'b1);
        send_item(CMD_PUSH, -64'sd5, 32'h0000_0000, '0, 1'b0);
        send_item(CMD_PUSH, 64'd10, 32'hA5A5_5A5A, '0, 1'b0);
        send_item(CMD_PUSH, TIME_MAX, 32'h0000_0001, '0, 1'b0);
        send_item(CMD_MATCH, '0, '0, TIME_MIN, 1'b0);
        send_item(CMD_MATCH, '0, '0, -64'sd6, 1'b0);
        send_item(CMD_MATCH, '0, '0, TIME_MAX, 1'b0);
        send_item(CMD_MATCH, '0, '0, 64'd20, 1'b0);
        send_item(CMD_PUSH, 64'd100, 32'h0000_1000, '0, 1'b0);
        send_item(CMD_PUSH, 64'd100, 32'h0000_2000, '0, 1'b0);
        send_item(CMD_MATCH, '0, '0, 64'd100, 1'b0);
        send_item(CMD_POP, '0, '0, '0, 1'b0);
        send_item(CMD_PUSH, 64'd200, 32'h0000_3000, '0, 1'b0);
        send_item(CMD_MATCH, '0, '0, 64'd100, 1'b0);
        send_item(CMD_MATCH, '0, '0, 64'd150, 1'b0);
        send_item(CMD_POP, '0, '0, '0, 1'b0);
        send_item(CMD_POP, '0, '0, '0, 1'b0);
        send_item(CMD_MATCH, '0, '0, 64'd150, 1'b0);

        // Reset capacity, mixed traffic
        newest_time = {$urandom, $urandom};
        repeat (80) random_item(5, 1, 3, 0);

        // Smallest capacity, then zero which acts as one
        write_capacity(8'd1);
        rx_mode = 2;
        repeat (40) random_item(3, 1, 3, 0);
        write_capacity(8'd0);
        repeat (30) random_item(3, 1, 3, 0);

        // Above depth: fill the storage while the receiver holds off
        write_capacity(8'd255);
        steady_sender = 1'b1;
        rx_mode = 0;
        hold_request = 300;
        repeat (150) random_item(1, 0, 0, 0);
        steady_sender = 1'b0;
        rx_mode = 1;
        repeat (20) random_item(1, 1, 2, 0);

        // Full depth with long match walks
        write_capacity(8'd128);
        match_reach = 3000;
        repeat (60) random_item(2, 1, 3, 0);

        // Capacity lowered below the fill
        write_capacity(8'd10);
        match_reach = 300;
        repeat (40) random_item(6, 1, 1, 0);

        write_capacity(8'd200);
        repeat (20) random_item(4, 1, 2, 0);
        write_capacity(8'd64);
        rx_mode = 2;
        newest_time = {$urandom, $urandom};
        repeat (40) random_item(3, 1, 3, 0);

        // Closed queue: stored entries, pushes while closed, clearing close
        rx_mode = 1;
        send_item(CMD_PUSH, newest_time + 64'd10, $urandom, '0, 1'b0);
        send_item(CMD_PUSH, newest_time + 64'd20, $urandom, '0, 1'b0);
        send_item(CMD_PUSH, newest_time + 64'd30, $urandom, '0, 1'b0);
        send_item(CMD_CLOSE, '0, '0, '0, 1'b0);
        send_item(CMD_MATCH, '0, '0, newest_time + 64'd15, 1'b0);
        send_item(CMD_MATCH, '0, '0, newest_time + 64'd5, 1'b0);
        send_item(CMD_POP, '0, '0, '0, 1'b0);
        send_item(CMD_PUSH, newest_time + 64'd40, $urandom, '0, 1'b0);
        repeat (6) send_item(CMD_POP, '0, '0, '0, 1'b0);
        send_item(CMD_PUSH, newest_time + 64'd50, $urandom, '0, 1'b0);
        send_item(CMD_CLOSE, '0, '0, '0, 1'b1);
        send_item(CMD_MATCH, '0, '0, newest_time, 1'b0);
        newest_time = newest_time + 64'd60;
        repeat (30) random_item(3, 3, 2, 1);
        send_item(CMD_CLOSE, '0, '0, '0, 1'b1);

        drain_results();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_timestamp_match_frame_queue: clean");
        else
            $display("tb_timestamp_match_frame_queue: errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/tmfq_pkg.sv
sv/tmfq_datapath.sv
sv/tmfq_ctrl.sv
sv/timestamp_match_frame_queue.sv
verif/tmfq_result_checker.sv
verif/tb_timestamp_match_frame_queue.sv
